// ----- hdl/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths, sequencer states and control structs of the extended GCD unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int unsigned OpW   = 32;          // operand width
  localparam int unsigned CoefW = OpW + 1;     // signed coefficient width
  localparam int unsigned CntW  = $clog2(OpW); // divider step counter width

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } egcd_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/egcd_div.sv -----
// ----------------------------------------------------------------------------
// egcd_div
// Restoring divider, one quotient bit per cycle, MSB first. Each quotient bit
// also drives a shift-add of two coefficients, so the unit returns the
// remainder and both products coef * quotient modulo 2^CoefW.
// ----------------------------------------------------------------------------
module egcd_div
  import egcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctrl_t        ctrl_i,
  input  logic [OpW-1:0]   dividend_i,
  input  logic [OpW-1:0]   divisor_i,
  input  logic [CoefW-1:0] coef_a_i,
  input  logic [CoefW-1:0] coef_b_i,
  output div_stat_t        stat_o,
  output logic [OpW-1:0]   remainder_o,
  output logic [CoefW-1:0] prod_a_o,
  output logic [CoefW-1:0] prod_b_o
);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [OpW-1:0]   rp_q, rp_d;
  logic [OpW-1:0]   dvd_q, dvd_d;
  logic [CoefW-1:0] acc_a_q, acc_a_d;
  logic [CoefW-1:0] acc_b_q, acc_b_d;

  logic [OpW:0]     shifted;
  logic [OpW:0]     diff;
  logic             qbit;

  assign shifted = {rp_q, dvd_q[OpW-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign qbit    = ~diff[OpW];

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rp_d    = rp_q;
    dvd_d   = dvd_q;
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    if (ctrl_i.start) begin
      run_d   = 1'b1;
      cnt_d   = '0;
      rp_d    = '0;
      dvd_d   = dividend_i;
      acc_a_d = '0;
      acc_b_d = '0;
    end else if (run_q) begin
      rp_d    = qbit ? diff[OpW-1:0] : shifted[OpW-1:0];
      dvd_d   = {dvd_q[OpW-2:0], 1'b0};
      acc_a_d = {acc_a_q[CoefW-2:0], 1'b0} + (qbit ? coef_a_i : '0);
      acc_b_d = {acc_b_q[CoefW-2:0], 1'b0} + (qbit ? coef_b_i : '0);
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CntW'(OpW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q    <= rp_d;
    dvd_q   <= dvd_d;
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign remainder_o = rp_q;
  assign prod_a_o    = acc_a_q;
  assign prod_b_o    = acc_b_q;

endmodule

// ----- hdl/extended_gcd_unit.sv -----
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Extended Euclidean algorithm: gcd(a,b) and coefficients s, t with
// s*a + t*b = gcd, using one shared bit-serial divider per Euclid step.
// ----------------------------------------------------------------------------
// Each Euclid step: a check state starts the divider, a divide state waits
// for its done; a check that finds a zero remainder ends the transaction.
// Throughput: one transaction at a time; busy stays high until the result.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset clears the sequencer and the strobe; data registers are not reset.
// ----------------------------------------------------------------------------
module extended_gcd_unit
  import egcd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [OpW-1:0]          value_a_i,
  input  logic [OpW-1:0]          value_b_i,
  output logic                    result_valid_o,
  output logic [OpW-1:0]          gcd_value_o,
  output logic signed [CoefW-1:0] bezout_s_o,
  output logic signed [CoefW-1:0] bezout_t_o
);

  egcd_state_e state_q, state_d;

  logic [OpW-1:0]   r_prev_q, r_cur_q;
  logic [CoefW-1:0] sa_prev_q, sa_cur_q;
  logic [CoefW-1:0] sb_prev_q, sb_cur_q;

  logic [OpW-1:0]   gcd_q;
  logic [CoefW-1:0] s_q, t_q;
  logic             valid_q;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [OpW-1:0]   div_rem;
  logic [CoefW-1:0] prod_a, prod_b;

  logic accept, finish, update;

  egcd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (r_prev_q),
    .divisor_i   (r_cur_q),
    .coef_a_i    (sa_cur_q),
    .coef_b_i    (sb_cur_q),
    .stat_o      (div_stat),
    .remainder_o (div_rem),
    .prod_a_o    (prod_a),
    .prod_b_o    (prod_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = (r_cur_q == '0) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_CHECK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = 1'b1;
    accept         = 1'b0;
    finish         = 1'b0;
    update         = 1'b0;
    div_ctrl.start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_CHECK: begin
        finish         = (r_cur_q == '0);
        div_ctrl.start = (r_cur_q != '0);
      end
      ST_DIV: begin
        update = div_stat.done;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= finish;
    end
  end

  // Euclid registers: load operands, then shift the pairs after each division
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_prev_q  <= value_a_i;
      r_cur_q   <= value_b_i;
      sa_prev_q <= CoefW'(1);
      sa_cur_q  <= '0;
      sb_prev_q <= '0;
      sb_cur_q  <= CoefW'(1);
    end else if (update) begin
      r_prev_q  <= r_cur_q;
      r_cur_q   <= div_rem;
      sa_prev_q <= sa_cur_q;
      sa_cur_q  <= sa_prev_q - prod_a;
      sb_prev_q <= sb_cur_q;
      sb_cur_q  <= sb_prev_q - prod_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      gcd_q <= r_prev_q;
      s_q   <= sa_prev_q;
      t_q   <= sb_prev_q;
    end
  end

  assign result_valid_o = valid_q;
  assign gcd_value_o    = gcd_q;
  assign bezout_s_o     = s_q;
  assign bezout_t_o     = t_q;

endmodule
